// ----- rtl/ecsm_pkg.sv -----
package ecsm_pkg;

   localparam int MaxLanes    = 8;
   localparam int NumChannels = 8;

   localparam int ByteW   = 8;
   localparam int LenW    = 16;
   localparam int PosW    = 32;
   localparam int StepW   = 18;
   localparam int OffW    = 16;
   localparam int SumW    = 11;  // eight signed bytes
   localparam int CountW  = 4;
   localparam int RecipW  = 17;
   localparam int RecipSh = 16;

   localparam int ReqDataW = 88;  // 83 bits of fields, padded to bytes
   localparam int RspDataW = 152;
   localparam int CsrDataW = StepW;

   localparam logic [LenW-1:0]  HeaderBytes = 16'd8;
   localparam logic [OffW-1:0]  DacCmdBits  = 16'h3000;
   localparam logic [StepW-1:0] UnityStep   = 18'h10000;

   // request kinds
   localparam logic CmdStart = 1'b0;
   localparam logic CmdTick  = 1'b1;

   // register indexes
   localparam logic CsrMixerEnabled = 1'b0;
   localparam logic CsrPitchStep    = 1'b1;

   typedef struct packed {
      logic                    hit;     // channel contributed on the last tick
      logic signed [ByteW-1:0] delta;   // byte - 128, zero when no hit
      logic                    active;
      logic [OffW-1:0]         offset;
   } lane_out_type;

   // ceil(2^16 / n): exact floor quotient for dividends up to 1024
   function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] n);
      logic [RecipW-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ecsm_lane.sv -----
module ecsm_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                cmd,
   input  logic [2:0]                          channel,
   input  logic [ecsm_pkg::LenW-1:0]           sample_length,
   input  logic [ecsm_pkg::ByteW-1:0]          sample_byte,
   input  logic                                mixer_enabled,
   input  logic [ecsm_pkg::StepW-1:0]          pitch_step,
   output ecsm_pkg::lane_out_type              lane_out
);

   localparam logic [2:0] LaneSel = 3'(LANE_INDEX);

   logic [ecsm_pkg::PosW-1:0]          pos_ff, pos_in;
   logic [ecsm_pkg::LenW-1:0]          end_ff, end_in;
   logic                               playing_ff, playing_in;
   logic                               hit_ff, hit_in;
   logic signed [ecsm_pkg::ByteW-1:0]  delta_ff, delta_in;
   logic [ecsm_pkg::OffW:0]            off_sum;

   always_comb begin
      pos_in     = pos_ff;
      end_in     = end_ff;
      playing_in = playing_ff;
      hit_in     = hit_ff;
      delta_in   = delta_ff;
      if (accept) begin
         hit_in   = 1'b0;
         delta_in = '0;
         if (cmd == ecsm_pkg::CmdStart) begin
            if (channel == LaneSel) begin
               pos_in = '0;
               if (sample_length > ecsm_pkg::HeaderBytes) begin
                  end_in     = sample_length - ecsm_pkg::HeaderBytes;
                  playing_in = 1'b1;
               end else begin
                  end_in     = '0;
                  playing_in = 1'b0;
               end
            end
         end else if (mixer_enabled && playing_ff) begin
            if (pos_ff[31:16] < end_ff) begin
               hit_in   = 1'b1;
               // flip the top bit: unsigned byte minus 128
               delta_in = {~sample_byte[7], sample_byte[6:0]};
               pos_in   = pos_ff + {14'd0, pitch_step};
            end else begin
               playing_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         end_ff     <= '0;
         playing_ff <= 1'b0;
         hit_ff     <= 1'b0;
         delta_ff   <= '0;
      end else begin
         pos_ff     <= pos_in;
         end_ff     <= end_in;
         playing_ff <= playing_in;
         hit_ff     <= hit_in;
         delta_ff   <= delta_in;
      end
   end

   assign off_sum = {1'b0, pos_ff[31:16]} + {1'b0, ecsm_pkg::HeaderBytes};

   always_comb begin
      lane_out.hit    = hit_ff;
      lane_out.delta  = delta_ff;
      lane_out.active = playing_ff;
      lane_out.offset = off_sum[ecsm_pkg::OffW] ? '1 : off_sum[ecsm_pkg::OffW-1:0];
   end

endmodule

// ----- rtl/ecsm_merge.sv -----
module ecsm_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            accept,
   input  ecsm_pkg::lane_out_type [ecsm_pkg::MaxLanes-1:0] lanes,
   output logic                                            idle,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [ecsm_pkg::RspDataW-1:0]                   rsp_tdata,
   output logic [0:0]                                      rsp_tuser
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StSum  = 2'd1;
   localparam logic [1:0] StMul  = 2'd2;
   localparam logic [1:0] StDone = 2'd3;

   localparam int ProdW = ecsm_pkg::SumW + ecsm_pkg::RecipW;

   logic [1:0]                          state_ff, state_in;
   logic [ecsm_pkg::SumW-1:0]           mag_ff, mag_in;
   logic                                neg_ff, neg_in;
   logic [ecsm_pkg::CountW-1:0]         count_ff, count_in;
   logic [ecsm_pkg::SumW-1:0]           quot_ff, quot_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ecsm_pkg::RspDataW-1:0]       rsp_data_ff, rsp_data_in;
   logic                                rsp_user_ff, rsp_user_in;

   logic signed [ecsm_pkg::SumW:0]      sum;
   logic [ecsm_pkg::CountW-1:0]         count;
   logic signed [ecsm_pkg::SumW:0]      neg_sum;
   logic [ProdW-1:0]                    prod;
   logic signed [ecsm_pkg::SumW+1:0]    mixed;
   logic [ecsm_pkg::ByteW-1:0]          clamped;
   logic                                out_free;

   always_comb begin
      sum   = '0;
      count = '0;
      for (int i = 0; i < ecsm_pkg::MaxLanes; i++) begin
         sum   = sum + (ecsm_pkg::SumW+1)'(lanes[i].delta);
         count = count + ecsm_pkg::CountW'(lanes[i].hit);
      end
      neg_sum = -sum;
   end

   assign prod = ProdW'(mag_ff) * ProdW'(ecsm_pkg::recip(count_ff));

   always_comb begin
      if (neg_ff) begin
         mixed = 13'sd128 - $signed({2'b00, quot_ff});
      end else begin
         mixed = 13'sd128 + $signed({2'b00, quot_ff});
      end
      if (mixed > 13'sd255) begin
         clamped = 8'd255;
      end else if (mixed < 13'sd0) begin
         clamped = 8'd0;
      end else begin
         clamped = mixed[ecsm_pkg::ByteW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StSum;
            end
         end
         StSum: begin
            neg_in   = sum[ecsm_pkg::SumW];
            mag_in   = sum[ecsm_pkg::SumW] ? neg_sum[ecsm_pkg::SumW-1:0]
                                           : sum[ecsm_pkg::SumW-1:0];
            count_in = count;
            state_in = StMul;
         end
         StMul: begin
            quot_in  = prod[ecsm_pkg::RecipSh +: ecsm_pkg::SumW];
            state_in = StDone;
         end
         StDone: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = (count_ff != '0);
               rsp_data_in[15:0] = (count_ff != '0)
                  ? (ecsm_pkg::DacCmdBits | {4'd0, clamped, 4'd0}) : '0;
               for (int i = 0; i < ecsm_pkg::MaxLanes; i++) begin
                  rsp_data_in[16 + i]    = lanes[i].active;
                  rsp_data_in[24 + 16*i +: 16] = lanes[i].offset;
               end
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      count_ff    <= count_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign idle       = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/eight_channel_sample_mixer_unit.sv -----
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser: cmd; tdata: channel, length, 8 bytes
// rsp      out        rsp_tvalid/rsp_tready  tuser: sample_valid; tdata: dac, mask, offsets
// csr      in         csr_valid/csr_ready    csr_index, csr_data; always ready
//
// One request at a time: the lanes update at the accepting edge, then the result is worked out
// in steps (sum and count, reciprocal multiply, bias and clamp) into the output register, so no
// new request is taken while one is in flight.
// The next request is taken once the result sits in the output register.
// Reset (synchronous) stops every channel, zeroes positions and disables the mixer.
// A stalled result holds the last stage; nothing is lost.
module eight_channel_sample_mixer_unit #(
   parameter int NUM_CHANNELS = ecsm_pkg::NumChannels
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] channel, [18:3] sample_length, [82:19] sample_byte_0..7, rest zero
   input  logic [ecsm_pkg::ReqDataW-1:0]   req_tdata,
   // [0] cmd
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] dac_word, [23:16] active_mask, [151:24] fetch_offset_0..7
   output logic [ecsm_pkg::RspDataW-1:0]   rsp_tdata,
   // [0] sample_valid
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [ecsm_pkg::CsrDataW-1:0]   csr_data
);

   logic                                            enabled_ff, enabled_in;
   logic [ecsm_pkg::StepW-1:0]                      step_ff, step_in;
   logic                                            accept;
   logic                                            idle;
   ecsm_pkg::lane_out_type [ecsm_pkg::MaxLanes-1:0] lanes;

   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign accept     = req_tvalid && idle;

   always_comb begin
      enabled_in = enabled_ff;
      step_in    = step_ff;
      if (csr_valid) begin
         case (csr_index[0])
            ecsm_pkg::CsrMixerEnabled: enabled_in = csr_data[0];
            ecsm_pkg::CsrPitchStep:    step_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         step_ff    <= ecsm_pkg::UnityStep;
      end else begin
         enabled_ff <= enabled_in;
         step_ff    <= step_in;
      end
   end

   for (genvar c = 0; c < ecsm_pkg::MaxLanes; c++) begin : g_lane
      if (c < NUM_CHANNELS) begin : g_on
         ecsm_lane #(
            .LANE_INDEX (c)
         ) u_lane (
            .clock         (clock),
            .reset         (reset),
            .accept        (accept),
            .cmd           (req_tuser[0]),
            .channel       (req_tdata[2:0]),
            .sample_length (req_tdata[18:3]),
            .sample_byte   (req_tdata[19 + 8*c +: 8]),
            .mixer_enabled (enabled_ff),
            .pitch_step    (step_ff),
            .lane_out      (lanes[c])
         );
      end else begin : g_off
         assign lanes[c] = '0;
      end
   end

   ecsm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .lanes      (lanes),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
